// ===== sv/brl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

    // screen and field sizes
    localparam int SCREEN_W = 1024;
    localparam int SCREEN_H = 1024;
    localparam int COORD_W  = 13;
    localparam int PIX_W    = 10;
    localparam int ERR_W    = 13;
    localparam int COLOR_W  = 32;
    localparam int ADDR_W   = 23;
    localparam int PITCH_W  = 13;

    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(1024);

    // command codes on the input channel
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_START   = 2'b00,
        OP_DROP    = 2'b01,
        OP_ADVANCE = 2'b10
    } op_kind_t;

    typedef struct packed {
        op_kind_t                 kind;
        logic [PIX_W-1:0]         x0;
        logic [PIX_W-1:0]         y0;
        logic [PIX_W-1:0]         x1;
        logic [PIX_W-1:0]         y1;
        logic [PIX_W-1:0]         dx;
        logic [PIX_W-1:0]         dy_mag;
        logic signed [ERR_W-1:0]  err;
        logic                     steep;
        logic                     down;
        logic [COLOR_W-1:0]       c0;
        logic [COLOR_W-1:0]       c1;
    } op_t;

    // one pixel before address forming
    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pix_t;

endpackage

`default_nettype wire

// ===== sv/brl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brl_front (
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire logic                              command,
    input  wire logic signed [brl_pkg::COORD_W-1:0] start_x,
    input  wire logic signed [brl_pkg::COORD_W-1:0] start_y,
    input  wire logic [brl_pkg::COLOR_W-1:0]       start_color,
    input  wire logic signed [brl_pkg::COORD_W-1:0] end_x,
    input  wire logic signed [brl_pkg::COORD_W-1:0] end_y,
    input  wire logic [brl_pkg::COLOR_W-1:0]       end_color,
    output logic                                   op_valid,
    input  wire logic                              op_ready,
    output brl_pkg::op_t                           op
);
    import brl_pkg::*;

    localparam logic signed [COORD_W:0] SCREEN_W_S = (COORD_W+1)'(SCREEN_W);
    localparam logic signed [COORD_W:0] SCREEN_H_S = (COORD_W+1)'(SCREEN_H);

    logic signed [COORD_W:0] sx, sy, ex, ey;
    logic signed [COORD_W:0] x0, y0, x1, y1;
    logic                    swap;
    logic                    on_screen;
    logic [PIX_W-1:0]        dx;
    logic signed [PIX_W:0]   dy;
    logic [PIX_W-1:0]        dy_mag;
    logic                    steep;
    logic                    down;

    // widen endpoints
    assign sx = {start_x[COORD_W-1], start_x};
    assign sy = {start_y[COORD_W-1], start_y};
    assign ex = {end_x[COORD_W-1], end_x};
    assign ey = {end_y[COORD_W-1], end_y};

    // order endpoints so x rises
    assign swap = (ex < sx);
    assign x0   = swap ? ex : sx;
    assign y0   = swap ? ey : sy;
    assign x1   = swap ? sx : ex;
    assign y1   = swap ? sy : ey;

    // screen bounds check on both endpoints
    assign on_screen = (x0 >= 0) && (x0 < SCREEN_W_S) && (y0 >= 0) && (y0 < SCREEN_H_S)
                    && (x1 >= 0) && (x1 < SCREEN_W_S) && (y1 >= 0) && (y1 < SCREEN_H_S);

    // deltas and octant
    assign dx     = x1[PIX_W-1:0] - x0[PIX_W-1:0];
    assign dy     = $signed({1'b0, y1[PIX_W-1:0]}) - $signed({1'b0, y0[PIX_W-1:0]});
    assign dy_mag = dy[PIX_W] ? PIX_W'(-dy) : dy[PIX_W-1:0];
    assign steep  = !(dx > dy_mag);
    assign down   = dy[PIX_W] || (dy == '0);

    // classified operation
    always_comb
    begin
        op.x0     = x0[PIX_W-1:0];
        op.y0     = y0[PIX_W-1:0];
        op.x1     = x1[PIX_W-1:0];
        op.y1     = y1[PIX_W-1:0];
        op.dx     = dx;
        op.dy_mag = dy_mag;
        op.steep  = steep;
        op.down   = down;
        op.c0     = swap ? end_color : start_color;
        op.c1     = swap ? start_color : end_color;
        if (steep)
        begin
            op.err = $signed({2'b00, dx, 1'b0}) - $signed({3'b000, dy_mag});
        end
        else
        begin
            op.err = $signed({2'b00, dy_mag, 1'b0}) - $signed({3'b000, dx});
        end
        if (command == CMD_ADVANCE)
        begin
            op.kind = OP_ADVANCE;
        end
        else if (on_screen)
        begin
            op.kind = OP_START;
        end
        else
        begin
            op.kind = OP_DROP;
        end
    end

    assign op_valid  = cmd_valid;
    assign cmd_ready = op_ready;

endmodule

`default_nettype wire

// ===== sv/brl_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brl_queue (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire brl_pkg::op_t push_op,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output brl_pkg::op_t pop_op
);
    import brl_pkg::*;

    op_t        entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== sv/brl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brl_back (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    op_valid,
    output logic         op_ready,
    input  wire brl_pkg::op_t op,
    output logic         pix_valid,
    input  wire logic    pix_ready,
    output brl_pkg::pix_t pix
);
    import brl_pkg::*;

    logic                    busy_reg, busy_next;
    logic [PIX_W-1:0]        cur_x_reg, cur_x_next;
    logic [PIX_W-1:0]        cur_y_reg, cur_y_next;
    logic [PIX_W-1:0]        stop_x_reg, stop_x_next;
    logic [PIX_W-1:0]        stop_y_reg, stop_y_next;
    logic [PIX_W-1:0]        dx_reg, dx_next;
    logic [PIX_W-1:0]        dy_mag_reg, dy_mag_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic                    steep_reg, steep_next;
    logic                    down_reg, down_next;
    logic [COLOR_W-1:0]      body_reg, body_next;
    logic [COLOR_W-1:0]      tail_reg, tail_next;
    logic                    pix_valid_reg, pix_valid_next;
    pix_t                    pix_reg, pix_next;

    logic                    advance;
    logic                    pop;
    logic                    emit;
    pix_t                    emit_pix;
    logic [PIX_W:0]          nx;
    logic signed [PIX_W+1:0] ny;
    logic                    interior;
    logic                    err_pos;
    logic signed [ERR_W-1:0] two_dx, two_dy;

    assign advance  = !pix_valid_reg || pix_ready;
    assign op_ready = advance;
    assign pop      = op_valid && advance;

    // one bresenham step
    assign nx       = {1'b0, cur_x_reg} + 1'b1;
    assign ny       = down_reg ? (PIX_W+2)'($signed({2'b00, cur_y_reg}) - 1)
                               : (PIX_W+2)'($signed({2'b00, cur_y_reg}) + 1);
    assign interior = steep_reg ? (down_reg ? (ny > $signed({2'b00, stop_y_reg}))
                                            : (ny < $signed({2'b00, stop_y_reg})))
                                : (nx < {1'b0, stop_x_reg});
    assign err_pos  = (err_reg > 0);
    assign two_dx   = $signed({2'b00, dx_reg, 1'b0});
    assign two_dy   = $signed({2'b00, dy_mag_reg, 1'b0});

    // state update per operation
    always_comb
    begin
        busy_next   = busy_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        stop_x_next = stop_x_reg;
        stop_y_next = stop_y_reg;
        dx_next     = dx_reg;
        dy_mag_next = dy_mag_reg;
        err_next    = err_reg;
        steep_next  = steep_reg;
        down_next   = down_reg;
        body_next   = body_reg;
        tail_next   = tail_reg;
        emit        = 1'b0;
        emit_pix    = '{x: stop_x_reg, y: stop_y_reg, color: tail_reg, last: 1'b1};
        case (op.kind)
            OP_START:
            begin
                busy_next   = 1'b1;
                cur_x_next  = op.x0;
                cur_y_next  = op.y0;
                stop_x_next = op.x1;
                stop_y_next = op.y1;
                dx_next     = op.dx;
                dy_mag_next = op.dy_mag;
                err_next    = op.err;
                steep_next  = op.steep;
                down_next   = op.down;
                body_next   = op.c0;
                tail_next   = op.c1;
                emit        = 1'b1;
                emit_pix    = '{x: op.x0, y: op.y0, color: op.c0, last: 1'b0};
            end
            OP_DROP:
            begin
                busy_next = 1'b0;
            end
            OP_ADVANCE:
            begin
                if (busy_reg)
                begin
                    emit = 1'b1;
                    if (interior && !steep_reg)
                    begin
                        cur_x_next = nx[PIX_W-1:0];
                        emit_pix   = '{x: nx[PIX_W-1:0], y: cur_y_reg, color: body_reg,
                                       last: 1'b0};
                        err_next   = err_reg + two_dy - (err_pos ? two_dx : '0);
                        if (err_pos)
                        begin
                            cur_y_next = down_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                        end
                    end
                    else if (interior)
                    begin
                        cur_y_next = ny[PIX_W-1:0];
                        emit_pix   = '{x: cur_x_reg, y: ny[PIX_W-1:0], color: body_reg,
                                       last: 1'b0};
                        err_next   = err_reg + two_dx - (err_pos ? two_dy : '0);
                        if (err_pos)
                        begin
                            cur_x_next = cur_x_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
            end
            default:
            begin
                busy_next = busy_reg;
            end
        endcase
    end

    // output register
    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        pix_next       = pix_reg;
        if (advance)
        begin
            pix_valid_next = pop && emit;
            pix_next       = emit_pix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= busy_next;
            end
            pix_valid_reg <= pix_valid_next;
        end
    end

    // line state, loaded on each popped operation
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            stop_x_reg <= stop_x_next;
            stop_y_reg <= stop_y_next;
            dx_reg     <= dx_next;
            dy_mag_reg <= dy_mag_next;
            err_reg    <= err_next;
            steep_reg  <= steep_next;
            down_reg   <= down_next;
            body_reg   <= body_next;
            tail_reg   <= tail_next;
        end
        pix_reg <= pix_next;
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule

`default_nettype wire

// ===== sv/brl_addr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brl_addr (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [brl_pkg::PITCH_W-1:0]   row_pitch,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire brl_pkg::pix_t                 in_pix,
    output logic                               pixel_valid,
    input  wire logic                          pixel_ready,
    output logic [brl_pkg::PIX_W-1:0]          pixel_x,
    output logic [brl_pkg::PIX_W-1:0]          pixel_y,
    output logic [brl_pkg::ADDR_W-1:0]         pixel_address,
    output logic [brl_pkg::COLOR_W-1:0]        pixel_color,
    output logic                               last_pixel
);
    import brl_pkg::*;

    logic                 valid_reg, valid_next;
    pix_t                 pix_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    addr_next;
    logic                 take;

    assign take     = !valid_reg || pixel_ready;
    assign in_ready = take;

    // address: x plus pitch times y, low bits kept
    assign addr_next = ADDR_W'(row_pitch) * ADDR_W'(in_pix.y) + ADDR_W'(in_pix.x);

    always_comb
    begin
        valid_next = take ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pix_reg  <= in_pix;
            addr_reg <= addr_next;
        end
    end

    assign pixel_valid   = valid_reg;
    assign pixel_x       = pix_reg.x;
    assign pixel_y       = pix_reg.y;
    assign pixel_address = addr_reg;
    assign pixel_color   = pix_reg.color;
    assign last_pixel    = pix_reg.last;

endmodule

`default_nettype wire

// ===== sv/bresenham_line_rasterizer.sv =====
// path: a pixel is registered in the operation queue, the stepper output register and the address register
// throughput: one command beat per cycle and one pixel per cycle unless pixel_ready stalls the output,
//   set by the single error add and compare of the stepping unit and the pitch multiply stage after it
// a two-entry command queue lets the classifier and the stepper stall apart
// reset: rst_n asynchronous, active low; clears the line, queue and output valids,
//   row pitch returns to 1024
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_enable,
    input  wire logic [brl_pkg::PITCH_W-1:0]       cfg_write_data,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire logic                              command,
    input  wire logic signed [brl_pkg::COORD_W-1:0] start_x,
    input  wire logic signed [brl_pkg::COORD_W-1:0] start_y,
    input  wire logic [brl_pkg::COLOR_W-1:0]       start_color,
    input  wire logic signed [brl_pkg::COORD_W-1:0] end_x,
    input  wire logic signed [brl_pkg::COORD_W-1:0] end_y,
    input  wire logic [brl_pkg::COLOR_W-1:0]       end_color,
    output logic                                   pixel_valid,
    input  wire logic                              pixel_ready,
    output logic [brl_pkg::PIX_W-1:0]              pixel_x,
    output logic [brl_pkg::PIX_W-1:0]              pixel_y,
    output logic [brl_pkg::ADDR_W-1:0]             pixel_address,
    output logic [brl_pkg::COLOR_W-1:0]            pixel_color,
    output logic                                   last_pixel
);
    import brl_pkg::*;

    logic [PITCH_W-1:0] row_pitch_reg;
    logic               fr_valid, fr_ready;
    op_t                fr_op;
    logic               q_valid, q_ready;
    op_t                q_op;
    logic               px_valid, px_ready;
    pix_t               px;

    // row pitch register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pitch_reg <= PITCH_RESET;
        end
        else if (cfg_write_enable)
        begin
            row_pitch_reg <= cfg_write_data;
        end
    end

    // command classifier
    brl_front u_front (
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command     (command),
        .start_x     (start_x),
        .start_y     (start_y),
        .start_color (start_color),
        .end_x       (end_x),
        .end_y       (end_y),
        .end_color   (end_color),
        .op_valid    (fr_valid),
        .op_ready    (fr_ready),
        .op          (fr_op)
    );

    // operation queue
    brl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_op    (fr_op),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_op     (q_op)
    );

    // line stepper
    brl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op_ready  (q_ready),
        .op        (q_op),
        .pix_valid (px_valid),
        .pix_ready (px_ready),
        .pix       (px)
    );

    // address stage and output register
    brl_addr u_addr (
        .clk           (clk),
        .rst_n         (rst_n),
        .row_pitch     (row_pitch_reg),
        .in_valid      (px_valid),
        .in_ready      (px_ready),
        .in_pix        (px),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_address (pixel_address),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel)
    );

endmodule

`default_nettype wire
